// ===== hdl/hts_pkg.sv =====
// Package for the heightfield triangle sampler: payload structs, register indexes,
// item kinds and fixed-point constants. It depends on nothing else.
package hts_pkg;

  localparam int GRID_SIDE_MAX_DEFAULT = 128;
  localparam int QUEUE_DEPTH           = 8;

  localparam int LOAD_INDEX_W = 14;
  localparam int COORD_W      = 32;
  localparam int HEIGHT_W     = 40;
  localparam int FRAC_W       = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;

  // One in Q.16 and half of the pixel range (2^23).
  localparam logic [FRAC_W+1:0] FRAC_ONE   = 18'd65536;
  localparam logic [32:0]       PIXEL_HALF = 33'd8388608;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_RECIP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_POINTS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_SCALE = 3'd4;

  typedef struct packed {
    logic                        kind;
    logic [LOAD_INDEX_W-1:0]     load_index;
    logic [31:0]                 pixel_word;
    logic signed [COORD_W-1:0]   world_x;
    logic signed [COORD_W-1:0]   world_z;
  } hts_item_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0]  height;
    logic                        outside;
  } hts_result_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic                        is_query;
    logic                        outside;
    logic                        write_ok;
    logic [FRAC_W-1:0]           fx;
    logic [FRAC_W-1:0]           fz;
    logic signed [HEIGHT_W-1:0]  value;
  } hts_cmd_t;

endpackage

// ===== hdl/hts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
module hts_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/hts_queue.sv =====
// Short first-in first-out queue between the front and back parts.
// Generic in width and depth; depends on nothing else.
module hts_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/hts_front.sv =====
// Front part: accepts items, converts load pixels to heights, maps query points
// to a cell, fractions and table address. Depends on hts_pkg.
module hts_front #(
  parameter int GRID_SIDE_MAX = 128,
  parameter int QDEPTH        = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  hts_pkg::hts_item_t                    item,
  input  logic signed [31:0]                    origin_x,
  input  logic signed [31:0]                    origin_z,
  input  logic [31:0]                           cell_recip,
  input  logic [7:0]                            height_scale,
  input  logic [$clog2(GRID_SIDE_MAX+1)-1:0]    gp,
  input  logic                                  credit_return,
  output logic                                  push,
  output hts_pkg::hts_cmd_t                     push_cmd,
  output logic [$clog2(GRID_SIDE_MAX*GRID_SIDE_MAX)-1:0] push_addr
);
  import hts_pkg::*;

  localparam int DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int GW    = $clog2(GRID_SIDE_MAX + 1);
  localparam int CW    = $clog2(GRID_SIDE_MAX);
  localparam int PW    = GW + CW;
  localparam int CMPW  = ((AW > LOAD_INDEX_W) ? AW : LOAD_INDEX_W) + 1;
  localparam int CRW   = $clog2(QDEPTH + 1);

  logic [CRW-1:0] credits;
  logic           accept;

  // Stage one registers.
  logic                        f1_valid;
  logic                        f1_kind;
  logic signed [32:0]          f1_tx;
  logic signed [32:0]          f1_tz;
  logic [LOAD_INDEX_W-1:0]     f1_index;
  logic signed [HEIGHT_W-1:0]  f1_value;

  // Stage two registers.
  logic                        f2_valid;
  logic                        f2_kind;
  logic                        f2_neg_x;
  logic                        f2_neg_z;
  logic [63:0]                 f2_prod_x;
  logic [63:0]                 f2_prod_z;
  logic [LOAD_INDEX_W-1:0]     f2_index;
  logic signed [HEIGHT_W-1:0]  f2_value;

  // Stage three registers.
  logic                        f3_valid;
  hts_cmd_t                    f3_cmd;
  logic [AW-1:0]               f3_addr;

  logic signed [32:0]          tx;
  logic signed [32:0]          tz;
  logic signed [32:0]          pix_sum;
  logic signed [41:0]          pix_prod;

  logic [31:0]                 cx;
  logic [31:0]                 cz;
  logic [31:0]                 gp_m1;
  logic                        outside;
  logic [PW-1:0]               row_off;
  logic [AW-1:0]               base;
  logic                        in_range;
  logic [CMPW-1:0]             index_ext;
  hts_cmd_t                    cmd_next;
  logic [AW-1:0]               addr_next;

  assign item_stall = (credits == '0);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= CRW'(QDEPTH);
    end else if (accept && !credit_return) begin
      credits <= credits - CRW'(1);
    end else if (credit_return && !accept) begin
      credits <= credits + CRW'(1);
    end
  end

  always_comb begin
    tx       = $signed({item.world_x[31], item.world_x}) - $signed({origin_x[31], origin_x});
    tz       = $signed({item.world_z[31], item.world_z}) - $signed({origin_z[31], origin_z});
    pix_sum  = $signed({item.pixel_word[31], item.pixel_word}) + $signed(PIXEL_HALF);
    pix_prod = 42'(pix_sum) * $signed({34'b0, height_scale});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_kind  <= item.kind;
      f1_tx    <= tx;
      f1_tz    <= tz;
      f1_index <= item.load_index;
      f1_value <= HEIGHT_W'(pix_prod >>> 7);
    end
  end

  // The shifted coordinate is below 2^32 when it is not negative, so the
  // product with the reciprocal fits 64 bits.
  always_ff @(posedge clk) begin
    f2_kind   <= f1_kind;
    f2_neg_x  <= f1_tx[32];
    f2_neg_z  <= f1_tz[32];
    f2_prod_x <= 64'(f1_tx[31:0]) * 64'(cell_recip);
    f2_prod_z <= 64'(f1_tz[31:0]) * 64'(cell_recip);
    f2_index  <= f1_index;
    f2_value  <= f1_value;
  end

  always_comb begin
    cx        = f2_prod_x[63:32];
    cz        = f2_prod_z[63:32];
    gp_m1     = 32'(gp) - 32'd1;
    outside   = (gp < GW'(2)) || f2_neg_x || f2_neg_z || (cx >= gp_m1) || (cz >= gp_m1);
    row_off   = PW'(gp) * PW'(cz[CW-1:0]);
    base      = AW'(cx[CW-1:0]) + AW'(row_off);
    index_ext = CMPW'(f2_index);
    in_range  = (index_ext < CMPW'(DEPTH));

    cmd_next.is_query = (f2_kind == KIND_QUERY);
    cmd_next.outside  = outside;
    cmd_next.write_ok = in_range;
    cmd_next.fx       = f2_prod_x[31:16];
    cmd_next.fz       = f2_prod_z[31:16];
    cmd_next.value    = f2_value;
    addr_next         = (f2_kind == KIND_QUERY) ? base : index_ext[AW-1:0];
  end

  always_ff @(posedge clk) begin
    f3_cmd  <= cmd_next;
    f3_addr <= addr_next;
  end

  assign push      = f3_valid;
  assign push_cmd  = f3_cmd;
  assign push_addr = f3_addr;

endmodule

// ===== hdl/hts_back.sv =====
// Back part: writes loaded heights, reads the four cell corners from four table
// copies and forms the barycentric weighted sum. Depends on hts_pkg and hts_ram.
module hts_back #(
  parameter int GRID_SIDE_MAX = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  hts_pkg::hts_cmd_t                     head_cmd,
  input  logic [$clog2(GRID_SIDE_MAX*GRID_SIDE_MAX)-1:0] head_addr,
  output logic                                  pop,
  input  logic [$clog2(GRID_SIDE_MAX+1)-1:0]    gp,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output hts_pkg::hts_result_t                  result
);
  import hts_pkg::*;

  localparam int DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int PRW   = HEIGHT_W + FRAC_W + 2;
  localparam int ACW   = PRW + 2;

  logic                        adv;
  logic                        wr_en;
  logic [AW-1:0]               rd_addr [4];
  logic [HEIGHT_W-1:0]         rd_data [4];

  logic                        b1_valid;
  logic                        b1_outside;
  logic [FRAC_W-1:0]           b1_fx;
  logic [FRAC_W-1:0]           b1_fz;

  logic                        b2_valid;
  logic                        b2_outside;
  logic signed [PRW-1:0]       b2_prod [3];

  logic [FRAC_W+1:0]           frac_sum;
  logic                        upper;
  logic [FRAC_W:0]             wgt [3];
  logic [HEIGHT_W-1:0]         hsel [3];
  logic signed [PRW-1:0]       opnd_h [3];
  logic signed [PRW-1:0]       opnd_w [3];
  logic signed [ACW-1:0]       acc;

  // The whole back pipeline moves together unless a finished result is held.
  assign adv   = !result_valid || !result_stall;
  assign pop   = head_valid && adv;
  assign wr_en = pop && !head_cmd.is_query && head_cmd.write_ok;

  // Corner order: h00, h10, h01, h11.
  always_comb begin
    rd_addr[0] = head_addr;
    rd_addr[1] = head_addr + AW'(1);
    rd_addr[2] = head_addr + AW'(gp);
    rd_addr[3] = head_addr + AW'(gp) + AW'(1);
  end

  for (genvar k = 0; k < 4; k++) begin : g_copy
    hts_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (head_addr),
      .wr_data (head_cmd.value),
      .rd_en   (adv),
      .rd_addr (rd_addr[k]),
      .rd_data (rd_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid     <= 1'b0;
      b2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      b1_valid     <= pop && head_cmd.is_query;
      b2_valid     <= b1_valid;
      result_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_outside <= head_cmd.outside;
      b1_fx      <= head_cmd.fx;
      b1_fz      <= head_cmd.fz;
    end
  end

  // Lower triangle: (1-fx-fz)*h00 + fx*h10 + fz*h01.
  // Upper triangle: (fx+fz-1)*h11 + (1-fz)*h10 + (1-fx)*h01.
  always_comb begin
    frac_sum = (FRAC_W+2)'(b1_fx) + (FRAC_W+2)'(b1_fz);
    upper    = (frac_sum > FRAC_ONE);
    if (upper) begin
      hsel[0] = rd_data[3];
      wgt[0]  = (FRAC_W+1)'(frac_sum - FRAC_ONE);
      wgt[1]  = (FRAC_W+1)'(FRAC_ONE - (FRAC_W+2)'(b1_fz));
      wgt[2]  = (FRAC_W+1)'(FRAC_ONE - (FRAC_W+2)'(b1_fx));
    end else begin
      hsel[0] = rd_data[0];
      wgt[0]  = (FRAC_W+1)'(FRAC_ONE - frac_sum);
      wgt[1]  = {1'b0, b1_fx};
      wgt[2]  = {1'b0, b1_fz};
    end
    hsel[1] = rd_data[1];
    hsel[2] = rd_data[2];
    for (int k = 0; k < 3; k++) begin
      opnd_h[k] = {{(PRW-HEIGHT_W){hsel[k][HEIGHT_W-1]}}, hsel[k]};
      opnd_w[k] = {{(PRW-FRAC_W-1){1'b0}}, wgt[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_outside <= b1_outside;
      for (int k = 0; k < 3; k++) begin
        b2_prod[k] <= opnd_h[k] * opnd_w[k];
      end
    end
  end

  always_comb begin
    acc = ACW'(b2_prod[0]) + ACW'(b2_prod[1]) + ACW'(b2_prod[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.outside <= b2_outside;
      result.height  <= b2_outside ? '0 : acc[FRAC_W+HEIGHT_W-1:FRAC_W];
    end
  end

endmodule

// ===== hdl/heightfield_triangle_sampler_unit.sv =====
// Top level of the heightfield triangle sampler: configuration registers, front
// part, command queue and back part. Depends on hts_pkg, hts_front, hts_queue, hts_back.
//
// The block holds a square grid of terrain heights (GRID_SIDE_MAX squared entries,
// signed Q24.16) and answers height queries by interpolating over one triangle of
// the grid cell that contains the query point. A load transaction converts a packed
// pixel into a height and stores it; it returns no result. A query transaction
// returns exactly one result: the interpolated height, or zero with the outside flag
// set when the point falls off the grid. The block takes one transaction per clock
// cycle, sustained while results are not stalled, for any mix of loads and queries.
// A query passes seven registers, the first of them loaded at the edge that accepts
// it: three front stages (origin subtraction, reciprocal multiply, cell and address),
// one in the queue, the table read, the weight multiplies and the output register.
// The single-cycle rate comes from keeping four copies of the height table, one per
// cell corner, each with one read port; every load with an index inside the table
// writes all four copies. The table is not cleared at reset, so a query must only
// touch entries that were loaded. The user must write configuration registers only
// while the block is idle; the block itself does not enforce it.
module heightfield_triangle_sampler_unit #(
  parameter int GRID_SIDE_MAX = hts_pkg::GRID_SIDE_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          cfg_write,
  input  logic [hts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                          item_valid,
  output logic                          item_stall,
  input  hts_pkg::hts_item_t            item,

  output logic                          result_valid,
  input  logic                          result_stall,
  output hts_pkg::hts_result_t          result
);
  import hts_pkg::*;

  localparam int DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int GW    = $clog2(GRID_SIDE_MAX + 1);
  localparam int GEW   = (GW > 8) ? GW : 8;
  localparam int QW    = AW + $bits(hts_cmd_t);

  // Configuration registers, with their reset values.
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_z;
  logic [31:0]        cell_recip;
  logic [7:0]         grid_points;
  logic [7:0]         height_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_z     <= '0;
      cell_recip   <= 32'd65536;
      grid_points  <= 8'd128;
      height_scale <= 8'd40;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORIGIN_X:     origin_x     <= cfg_data;
        CFG_ORIGIN_Z:     origin_z     <= cfg_data;
        CFG_CELL_RECIP:   cell_recip   <= cfg_data;
        CFG_GRID_POINTS:  grid_points  <= cfg_data[7:0];
        CFG_HEIGHT_SCALE: height_scale <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // A grid wider than the table is treated as the full table width.
  logic [GEW-1:0] gp_ext;
  logic [GW-1:0]  gp;

  always_comb begin
    gp_ext = GEW'(grid_points);
    gp     = (gp_ext > GEW'(GRID_SIDE_MAX)) ? GW'(GRID_SIDE_MAX) : gp_ext[GW-1:0];
  end

  logic           push;
  hts_cmd_t       push_cmd;
  logic [AW-1:0]  push_addr;
  logic           pop;
  logic           head_valid;
  logic [QW-1:0]  head_data;
  hts_cmd_t       head_cmd;
  logic [AW-1:0]  head_addr;

  // The front part only accepts a transaction when it holds a queue credit,
  // so the queue never overflows and the front never has to stall midway.
  hts_front #(
    .GRID_SIDE_MAX (GRID_SIDE_MAX),
    .QDEPTH        (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .origin_x      (origin_x),
    .origin_z      (origin_z),
    .cell_recip    (cell_recip),
    .height_scale  (height_scale),
    .gp            (gp),
    .credit_return (pop),
    .push          (push),
    .push_cmd      (push_cmd),
    .push_addr     (push_addr)
  );

  hts_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_addr, push_cmd}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_addr = head_data[QW-1:$bits(hts_cmd_t)];
  assign head_cmd  = head_data[$bits(hts_cmd_t)-1:0];

  // Loads and queries leave the queue in order, so a query always sees
  // every load that was accepted ahead of it.
  hts_back #(
    .GRID_SIDE_MAX (GRID_SIDE_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .head_addr    (head_addr),
    .pop          (pop),
    .gp           (gp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== hdl/hts_checker.sv =====
// Port-level checker for the heightfield triangle sampler, bound to the top level.
// Depends on hts_pkg and heightfield_triangle_sampler_unit.
module hts_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input hts_pkg::hts_result_t result
);
  import hts_pkg::*;

  // A held result does not change until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // An outside query always reports zero height.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.outside |-> result.height == '0)
    else $error("outside result with nonzero height");

  // Reset empties the pipeline and restores all queue credits.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

endmodule

bind heightfield_triangle_sampler_unit hts_checker u_hts_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== dv/heightfield_sample_checker.sv =====
// Checker for the heightfield triangle sampler: mirrors the height table and the
// registers, predicts each query result and compares it. Depends on hts_pkg.
module heightfield_sample_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [hts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  hts_pkg::hts_item_t              item,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  hts_pkg::hts_result_t            result,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hts_pkg::*;

  localparam int TABLE_DEPTH = GRID_SIDE_MAX_DEFAULT * GRID_SIDE_MAX_DEFAULT;
  // A pixel is normalized by 2^23 and the height kept in Q.16, so 7 bits go.
  localparam int PIXEL_SHIFT = 7;

  logic signed [COORD_W-1:0]  origin_x;
  logic signed [COORD_W-1:0]  origin_z;
  logic [31:0]                cell_recip;
  logic [7:0]                 grid_points;
  logic [7:0]                 height_scale;
  logic signed [HEIGHT_W-1:0] height_mirror [TABLE_DEPTH];
  hts_result_t                expected_results [$];
  hts_result_t                oldest;

  function automatic logic signed [HEIGHT_W-1:0] pixel_to_height(logic [31:0] pixel);
    longint p;
    p = longint'($signed(pixel));
    return HEIGHT_W'(((p + longint'(PIXEL_HALF)) * longint'(height_scale)) >>> PIXEL_SHIFT);
  endfunction

  function automatic hts_result_t sample_height(logic signed [COORD_W-1:0] wx,
                                                logic signed [COORD_W-1:0] wz);
    hts_result_t r;
    longint      gp, tx, tz, cx, cz, fx, fz, base, one, acc;
    longint      h00, h10, h01, h11;
    logic [65:0] px, pz;
    r.height  = '0;
    r.outside = 1'b1;
    one = longint'(FRAC_ONE);
    gp = (grid_points > GRID_SIDE_MAX_DEFAULT) ? GRID_SIDE_MAX_DEFAULT : grid_points;
    tx = longint'(wx) - longint'(origin_x);
    tz = longint'(wz) - longint'(origin_z);
    if (gp < 2 || tx < 0 || tz < 0) return r;
    // The exact product needs up to 64 bits; cell above bit 32, fraction below.
    px = tx;
    pz = tz;
    px = px * cell_recip;
    pz = pz * cell_recip;
    if (px[65:32] >= gp - 1 || pz[65:32] >= gp - 1) return r;
    cx = px[65:32];
    cz = pz[65:32];
    fx = px[31:16];
    fz = pz[31:16];
    base = cx + gp * cz;
    h00 = height_mirror[base];
    h10 = height_mirror[base + 1];
    h01 = height_mirror[base + gp];
    h11 = height_mirror[base + gp + 1];
    if (fx + fz <= one)
      acc = h00 * one + fx * (h10 - h00) + fz * (h01 - h00);
    else
      acc = (one - fz) * h10 + (fx + fz - one) * h11 + (one - fx) * h01;
    r.height  = HEIGHT_W'(acc >>> FRAC_W);
    r.outside = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      origin_x     = '0;
      origin_z     = '0;
      cell_recip   = 32'h0001_0000;
      grid_points  = 8'd128;
      height_scale = 8'd40;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ORIGIN_X:     origin_x     = cfg_data;
          CFG_ORIGIN_Z:     origin_z     = cfg_data;
          CFG_CELL_RECIP:   cell_recip   = cfg_data;
          CFG_GRID_POINTS:  grid_points  = cfg_data[7:0];
          CFG_HEIGHT_SCALE: height_scale = cfg_data[7:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        if (item.kind == KIND_LOAD)
          height_mirror[item.load_index] = pixel_to_height(item.pixel_word);
        else
          expected_results.push_back(sample_height(item.world_x, item.world_z));
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, height %0d outside %0b",
                   $time, result.height, result.outside);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (result.height !== oldest.height) begin
            $display("%0t: height mismatch, expected %0d, got %0d",
                     $time, oldest.height, result.height);
            fail_count++;
          end
          if (result.outside !== oldest.outside) begin
            $display("%0t: outside flag mismatch, expected %0b, got %0b",
                     $time, oldest.outside, result.outside);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/heightfield_triangle_sampler_unit_tb.sv =====
// Testbench top for the heightfield triangle sampler: clock, reset, stimulus and
// verdict. Depends on hts_pkg, heightfield_sample_checker and the block itself.
module heightfield_triangle_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hts_pkg::*;

  localparam int TABLE_DEPTH    = GRID_SIDE_MAX_DEFAULT * GRID_SIDE_MAX_DEFAULT;
  localparam int GAP_MAX        = 13;
  // This many quiet cycles covers loads still in flight between an accepted
  // transaction and its table write.
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 500;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  hts_item_t              item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  hts_result_t            result;
  int                     fail_count;
  int                     pending;

  // Our own copy of the register values, used only to steer the stimulus.
  logic [31:0] cur_ox = '0;
  logic [31:0] cur_oz = '0;
  logic [31:0] cur_recip = 32'h0001_0000;
  logic [7:0]  cur_gp = 8'd128;

  // Which table entries have been written since the start. The table is not
  // cleared at reset, so no query may touch a corner that is still unwritten.
  bit loaded [TABLE_DEPTH];
  // When set, neither side idles or stalls, giving full-rate stretches.
  bit back_to_back = 1'b0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  heightfield_triangle_sampler_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  heightfield_sample_checker i_height_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // The watchdog only counts cycles in which no transaction moves on either
  // channel; any accepted transaction starts the count again.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return back_to_back ? 0 : $urandom_range(GAP_MAX);
  endfunction

  function automatic int grid_side();
    return (cur_gp > GRID_SIDE_MAX_DEFAULT) ? GRID_SIDE_MAX_DEFAULT : int'(cur_gp);
  endfunction

  // Finds the table index of the lower corner of the cell that a query lands in.
  // It returns 0 when the point is off the grid, in which case nothing is read.
  function automatic bit locate_cell(logic [31:0] wx, logic [31:0] wz, output int base);
    longint      gp, tx, tz;
    logic [65:0] px, pz;
    base = 0;
    gp = grid_side();
    tx = longint'($signed(wx)) - longint'($signed(cur_ox));
    tz = longint'($signed(wz)) - longint'($signed(cur_oz));
    if (gp < 2 || tx < 0 || tz < 0) return 1'b0;
    px = tx;
    pz = tz;
    px = px * cur_recip;
    pz = pz * cur_recip;
    if (px[65:32] >= gp - 1 || pz[65:32] >= gp - 1) return 1'b0;
    base = int'(px[65:32] + gp * pz[65:32]);
    return 1'b1;
  endfunction

  // Pixels are mostly random, with the signed extremes and the values around
  // the zero-height point mixed in.
  function automatic logic [31:0] random_pixel();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'hFF80_0000;
      default: return $urandom;
    endcase
  endfunction

  // Picks a world coordinate on one axis. Most land inside the grid span
  // measured from the origin; some just below it, some just past the far edge
  // and some anywhere. Fractions are sometimes forced onto the triangle split.
  function automatic logic [31:0] pick_coord(logic [31:0] org);
    longint unsigned span, t;
    int              gp;
    gp = grid_side();
    if (gp < 2)
      span = 64'd1 << 20;
    else if (cur_recip == 0)
      span = 64'd1 << 32;
    else
      span = (longint'(gp - 1) << 32) / cur_recip;
    if (span > (64'd1 << 32)) span = 64'd1 << 32;
    if (span == 0) span = 1;
    case ($urandom_range(9))
      0: return $urandom;
      1: return org - $urandom_range(1, 1 << 17);
      2: return org + span[31:0] + $urandom_range(0, 1 << 17);
      default: begin
        t = {$urandom, $urandom} % span;
        case ($urandom_range(7))
          0: t[15:0] = 16'h0000;
          1: t[15:0] = 16'h8000;
          2: t[15:0] = 16'hFFFF;
          3: t[15:0] = 16'h7FFF;
          default: ;
        endcase
        return org + t[31:0];
      end
    endcase
  endfunction

  // Presents one transaction after a random gap and holds it until accepted.
  task automatic send_item(hts_item_t it);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // A load; the query fields ride along with random content since they are unused.
  task automatic load_height(int idx, logic [31:0] pixel);
    hts_item_t it;
    it.kind       = KIND_LOAD;
    it.load_index = idx[LOAD_INDEX_W-1:0];
    it.pixel_word = pixel;
    it.world_x    = $urandom;
    it.world_z    = $urandom;
    loaded[idx[LOAD_INDEX_W-1:0]] = 1'b1;
    send_item(it);
  endtask

  // A query; any of the four cell corners that were never written are loaded
  // first, so the block never reads an undefined entry.
  task automatic query_height(logic [31:0] wx, logic [31:0] wz);
    hts_item_t it;
    int        base, gp;
    int        corner [4];
    if (locate_cell(wx, wz, base)) begin
      gp = grid_side();
      corner = '{base, base + 1, base + gp, base + gp + 1};
      foreach (corner[k])
        if (!loaded[corner[k]]) load_height(corner[k], random_pixel());
    end
    it.kind       = KIND_QUERY;
    it.load_index = $urandom;
    it.pixel_word = $urandom;
    it.world_x    = wx;
    it.world_z    = wz;
    send_item(it);
  endtask

  // Brings the block to rest: no transaction offered, every result in, and the
  // drain time for loads that have no result to wait for.
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Every register is rewritten at each change of settings.
  task automatic write_settings(input logic [31:0] ox, input logic [31:0] oz,
                                input logic [31:0] recip, input logic [7:0] gp,
                                input logic [7:0] mh);
    settle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_CELL_RECIP, recip);
    write_reg(CFG_GRID_POINTS, {24'd0, gp});
    write_reg(CFG_HEIGHT_SCALE, {24'd0, mh});
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_ox    = ox;
    cur_oz    = oz;
    cur_recip = recip;
    cur_gp    = gp;
  endtask

  // Random traffic: queries around the grid, loads inside the grid in use and
  // loads anywhere in the table, with full-rate stretches switched on and off.
  task automatic random_traffic(int count);
    int pick, gp;
    repeat (count) begin
      if ($urandom_range(39) == 0) back_to_back = !back_to_back;
      gp = grid_side();
      pick = $urandom_range(19);
      if (pick < 9)
        query_height(pick_coord(cur_ox), pick_coord(cur_oz));
      else if (pick < 17 && gp >= 2)
        load_height($urandom_range(0, gp * gp - 1), random_pixel());
      else
        load_height($urandom_range(0, TABLE_DEPTH - 1), random_pixel());
    end
  endtask

  // The result side draws a stall length for every result, then waits for it.
  initial begin
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = draw_gap();
      @(negedge clk);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    logic [31:0] ox, oz;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset settings: unit cells, origin at zero, a full
    // grid. Loads cover the pixel extremes and the zero-height pixel; queries
    // cover the cell corner, the edge of the lower triangle (fx + fz equal to
    // one), just over it into the upper triangle, the largest fractions, a
    // negative coordinate, the last row and column, and extreme coordinates.
    load_height(0, 32'h0000_0000);
    load_height(1, 32'hFFFF_FFFF);
    load_height(128, 32'h7FFF_FFFF);
    load_height(129, 32'h8000_0000);
    load_height(TABLE_DEPTH - 1, 32'hFF80_0000);
    load_height(8192, 32'h0080_0000);
    query_height(32'h0000_0000, 32'h0000_0000);
    query_height(32'h0000_8000, 32'h0000_8000);
    query_height(32'h0000_8001, 32'h0000_8000);
    query_height(32'h0000_FFFF, 32'h0000_FFFF);
    query_height(32'h0000_FFFF, 32'h0000_0000);
    query_height(32'h0000_0000, 32'h0000_FFFF);
    query_height(32'hFFFF_FFFF, 32'h0000_0000);
    query_height(32'h0000_0000, 32'h8000_0000);
    query_height(32'h007F_0000, 32'h0000_0000);
    query_height(32'h007E_FFFF, 32'h007E_FFFF);
    query_height(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // The smallest grid, a single cell, with the largest height scale.
    write_settings(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 8'd2, 8'd255);
    random_traffic(90);

    // Offset origin and a cell size of 0.4, smallest nonzero height scale.
    write_settings(32'hFFFD_0000, 32'h0005_1234, 32'h0002_8000, 8'd16, 8'd1);
    random_traffic(110);

    // Extreme origins and the largest reciprocal; a zero height scale.
    write_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd128, 8'd0);
    random_traffic(80);

    // Zero reciprocal puts every point in the first cell; a grid value above
    // the table side is clamped to it.
    ox = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    oz = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    write_settings(ox, oz, 32'h0000_0000, 8'd255, 8'd128);
    random_traffic(80);

    // Grids too small to hold a cell: every query is off the grid.
    write_settings(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 8'd1, 8'd40);
    random_traffic(25);
    write_settings(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 8'd0, 8'd40);
    random_traffic(25);

    // The smallest reciprocal with the lowest origins: large shifted
    // coordinates all fall in the first column and row of cells.
    write_settings(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 8'd200, 8'd77);
    random_traffic(80);

    // Random settings with moderate cell sizes.
    repeat (2) begin
      ox = 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      oz = 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      write_settings(ox, oz, $urandom_range(1 << 12, 1 << 20),
                     8'($urandom_range(2, 128)), 8'($urandom_range(1, 255)));
      random_traffic(100);
    end

    back_to_back = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== heightfield_triangle_sampler_unit.f =====
hdl/hts_pkg.sv
hdl/hts_ram.sv
hdl/hts_queue.sv
hdl/hts_front.sv
hdl/hts_back.sv
hdl/heightfield_triangle_sampler_unit.sv
hdl/hts_checker.sv
dv/heightfield_sample_checker.sv
dv/heightfield_triangle_sampler_unit_tb.sv
